### hw/rtl/conv_pkg.sv
`timescale 1ns / 1ps
// conv_pkg: shared types and constants of the 8x8 valid-window convolution block
// depends on nothing; imported by every module of the block

package conv_pkg;

    localparam int KSIDE     = 8;
    localparam int LINES     = KSIDE - 1;
    localparam int KAREA     = KSIDE * KSIDE;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 11;
    localparam int POS_W     = 10;
    localparam int KIDX_W    = 3;
    localparam int RB_W      = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FPTR_W    = 2;
    localparam int FCNT_W    = 3;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 56;
    localparam logic [CFG_W-1:0] SIZE_RESET = 11'd64;

    localparam logic MODE_COEF  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    typedef logic [DATA_W-1:0] word_t;

    typedef struct packed {
        logic                        mode;
        word_t                       value;
        logic [KIDX_W-1:0]           coef_row;
        logic [KIDX_W-1:0]           coef_col;
        logic                        emit;
        logic                        last;
        logic [POS_W-1:0]            out_row;
        logic [POS_W-1:0]            out_col;
        logic [LINES-1:0][DATA_W-1:0] column;
    } conv_entry_t;

    typedef struct packed {
        logic [FCNT_W-1:0] count;
        logic              empty;
    } conv_fifo_stat_t;

    typedef struct packed {
        logic             last;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
    } conv_meta_t;

endpackage

### hw/rtl/conv_front.sv
`timescale 1ns / 1ps
// conv_front: takes requests, tracks pixel position, keeps the seven line stores
// depends on conv_pkg; feeds conv_fifo

module conv_front #(
    parameter int MAX_SIDE = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [conv_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [conv_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tuser,
    input  conv_pkg::conv_fifo_stat_t          fifo_stat,
    output logic                               push,
    output conv_pkg::conv_entry_t              push_entry
);
    import conv_pkg::*;

    localparam int CW = $clog2(MAX_SIDE);
    localparam int SW = CW + 1;

    logic [CFG_W-1:0]  size_reg;
    logic [CW-1:0]     row_reg, col_reg;
    logic [RB_W-1:0]   rb_reg, rb1_reg;
    logic              v1_reg;
    conv_entry_t       e1_reg;
    word_t             rd_reg [LINES];
    logic [31:0]       side_wide;
    logic [SW-1:0]     side;
    logic              acc, pix_acc;
    logic [SW-1:0]     col_inc, row_inc;
    logic [CW-1:0]     row_m, col_m;
    word_t             value;
    logic [RB_W+1:0]   ridx [LINES];

    assign cfg_ready = 1'b1;
    assign value     = s_tdata[DATA_W-1:0];

    always_comb begin
        side_wide = {21'd0, size_reg};
        if (side_wide == 32'd0) begin
            side_wide = 32'd1;
        end
        if (side_wide > 32'(MAX_SIDE)) begin
            side_wide = 32'(MAX_SIDE);
        end
        side = SW'(side_wide);
    end

    assign s_tready = ({1'b0, fifo_stat.count} + {{FCNT_W{1'b0}}, v1_reg})
                      < (FCNT_W + 1)'(FIFO_DEPTH);
    assign acc      = s_tvalid && s_tready;
    assign pix_acc  = acc && (s_tuser == MODE_PIXEL);
    assign col_inc  = {1'b0, col_reg} + SW'(1);
    assign row_inc  = {1'b0, row_reg} + SW'(1);
    assign row_m    = row_reg - CW'(LINES);
    assign col_m    = col_reg - CW'(LINES);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_RESET;
            row_reg  <= '0;
            col_reg  <= '0;
            rb_reg   <= '0;
            v1_reg   <= 1'b0;
        end else begin
            v1_reg <= acc;
            if (cfg_valid) begin
                size_reg <= cfg_data;
                row_reg  <= '0;
                col_reg  <= '0;
                rb_reg   <= '0;
            end else if (pix_acc) begin
                if (col_inc == side) begin
                    col_reg <= '0;
                    if (row_inc == side) begin
                        row_reg <= '0;
                        rb_reg  <= '0;
                    end else begin
                        row_reg <= CW'(row_inc);
                        rb_reg  <= (rb_reg == RB_W'(LINES - 1)) ? '0 : rb_reg + RB_W'(1);
                    end
                end else begin
                    col_reg <= CW'(col_inc);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            e1_reg.mode     <= s_tuser;
            e1_reg.value    <= value;
            e1_reg.coef_row <= s_tdata[DATA_W+KIDX_W-1:DATA_W];
            e1_reg.coef_col <= s_tdata[DATA_W+2*KIDX_W-1:DATA_W+KIDX_W];
            e1_reg.emit     <= (row_reg >= CW'(LINES)) && (col_reg >= CW'(LINES));
            e1_reg.last     <= (row_inc == side) && (col_inc == side);
            e1_reg.out_row  <= POS_W'(row_m);
            e1_reg.out_col  <= POS_W'(col_m);
            e1_reg.column   <= '0;
            rb1_reg         <= rb_reg;
        end
    end

    for (genvar g = 0; g < LINES; g++) begin : g_line
        word_t mem [MAX_SIDE];
        always_ff @(posedge aclk) begin
            if (pix_acc) begin
                rd_reg[g] <= mem[col_reg];
                if (rb_reg == RB_W'(g)) begin
                    mem[col_reg] <= value;
                end
            end
        end
    end

    // window row l takes line (rb + l) mod 7
    always_comb begin
        push_entry = e1_reg;
        for (int l = 0; l < LINES; l++) begin
            ridx[l] = {2'b00, rb1_reg} + (RB_W + 2)'(l);
            if (ridx[l] >= (RB_W + 2)'(LINES)) begin
                ridx[l] = ridx[l] - (RB_W + 2)'(LINES);
            end
            push_entry.column[l] = rd_reg[ridx[l][RB_W-1:0]];
        end
    end

    assign push = v1_reg;

endmodule

### hw/rtl/conv_fifo.sv
`timescale 1ns / 1ps
// conv_fifo: short request queue between front and back
// depends on conv_pkg

module conv_fifo (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  conv_pkg::conv_entry_t      din,
    input  logic                       pop,
    output conv_pkg::conv_entry_t      dout,
    output conv_pkg::conv_fifo_stat_t  stat
);
    import conv_pkg::*;

    conv_entry_t        buf_reg [FIFO_DEPTH];
    logic [FPTR_W-1:0]  wr_reg, rd_reg;
    logic [FCNT_W-1:0]  cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + FPTR_W'(1);
            end
            if (pop) begin
                rd_reg <= rd_reg + FPTR_W'(1);
            end
            cnt_reg <= cnt_reg + FCNT_W'(push) - FCNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_reg] <= din;
        end
    end

    assign dout       = buf_reg[rd_reg];
    assign stat.count = cnt_reg;
    assign stat.empty = (cnt_reg == '0);

endmodule

### hw/rtl/conv_back.sv
`timescale 1ns / 1ps
// conv_back: kernel store, 8x8 window, 64 multiplier lanes and a registered adder tree
// depends on conv_pkg; drains conv_fifo

module conv_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  conv_pkg::conv_fifo_stat_t      fifo_stat,
    input  conv_pkg::conv_entry_t          entry,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [conv_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import conv_pkg::*;

    localparam int N2 = KAREA / 4;
    localparam int N3 = N2 / 4;

    word_t       ker_reg [KAREA];
    word_t       win_reg [KAREA];
    word_t       prod_reg [KAREA];
    word_t       s2_reg [N2];
    word_t       s3_reg [N3];
    word_t       sum_reg;
    logic        v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    conv_meta_t  m0_reg, m1_reg, m2_reg, m3_reg, m4_reg;
    logic        en;

    assign en  = !v4_reg || m_tready;
    assign pop = !fifo_stat.empty && en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            for (int i = 0; i < KAREA; i++) begin
                ker_reg[i] <= '0;
            end
        end else if (en) begin
            v0_reg <= pop && (entry.mode == MODE_PIXEL) && entry.emit;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (pop && (entry.mode == MODE_COEF)) begin
                ker_reg[{entry.coef_row, entry.coef_col}] <= entry.value;
            end
        end
    end

    // window shifts left one column per pixel
    always_ff @(posedge aclk) begin
        if (pop && (entry.mode == MODE_PIXEL)) begin
            for (int l = 0; l < KSIDE; l++) begin
                for (int k = 0; k < KSIDE - 1; k++) begin
                    win_reg[l*KSIDE+k] <= win_reg[l*KSIDE+k+1];
                end
                win_reg[l*KSIDE+KSIDE-1] <= (l < LINES) ? entry.column[l] : entry.value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m0_reg <= '{last: entry.last, out_row: entry.out_row, out_col: entry.out_col};
            m1_reg <= m0_reg;
            m2_reg <= m1_reg;
            m3_reg <= m2_reg;
            m4_reg <= m3_reg;
            for (int i = 0; i < KAREA; i++) begin
                prod_reg[i] <= win_reg[i] * ker_reg[i];
            end
            for (int j = 0; j < N2; j++) begin
                s2_reg[j] <= prod_reg[4*j] + prod_reg[4*j+1] + prod_reg[4*j+2] + prod_reg[4*j+3];
            end
            for (int j = 0; j < N3; j++) begin
                s3_reg[j] <= s2_reg[4*j] + s2_reg[4*j+1] + s2_reg[4*j+2] + s2_reg[4*j+3];
            end
            sum_reg <= s3_reg[0] + s3_reg[1] + s3_reg[2] + s3_reg[3];
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tlast  = m4_reg.last;
    assign m_tdata  = {{(M_TDATA_W - DATA_W - 2*POS_W){1'b0}},
                       m4_reg.out_col, m4_reg.out_row, sum_reg};

endmodule

### hw/rtl/conv2d_8x8_valid.sv
`timescale 1ns / 1ps
// conv2d_8x8_valid: top level of the streaming 8x8 valid-window convolution
// depends on conv_pkg, conv_front, conv_fifo, conv_back

// Takes one request per clock while s_tready is high: tuser 0 loads a kernel coefficient
// at (coef_row, coef_col), tuser 1 delivers the next pixel in raster order. Each pixel that
// completes an 8x8 window raises m_tvalid after the line store read, the request queue,
// the window shift, one multiplier stage and three adder stages; throughput is one request
// per cycle while the queue has room, set by the single-port line stores and the 64
// parallel multiplier lanes.
// Writing image_size restarts the pixel position; write it only while the block is idle.
module conv2d_8x8_valid #(
    parameter int MAX_SIDE = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [conv_pkg::CFG_W-1:0]     cfg_data,      // image_size
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [conv_pkg::S_TDATA_W-1:0] s_tdata,       // value, coef_row, coef_col
    input  logic                           s_tuser,       // mode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [conv_pkg::M_TDATA_W-1:0] m_tdata,       // conv_sum, out_row, out_col
    output logic                           m_tlast        // last_of_image
);
    import conv_pkg::*;

    conv_fifo_stat_t fifo_stat;
    conv_entry_t     push_entry, head;
    logic            push, pop;

    conv_front #(.MAX_SIDE(MAX_SIDE)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .fifo_stat(fifo_stat), .push(push), .push_entry(push_entry)
    );

    conv_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .din(push_entry), .pop(pop), .dout(head), .stat(fifo_stat)
    );

    conv_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .fifo_stat(fifo_stat), .entry(head), .pop(pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

endmodule

### hw/rtl/conv_checker.sv
`timescale 1ns / 1ps
// conv_checker: port-level checks of conv2d_8x8_valid, bound to the top level
// depends on conv_pkg

module conv_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [conv_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);
    import conv_pkg::*;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result right after reset");

    a_last_diag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[41:32] == m_tdata[51:42])
        else $error("last result not on the diagonal");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[41:32] <= 10'd1016 && m_tdata[51:42] <= 10'd1016)
        else $error("window corner out of range");

endmodule

bind conv2d_8x8_valid conv_checker u_chk (.*);
